>>> sv/jtoc_pkg.sv
// Shared types, constants and helpers for the top-level JSON object counter.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package jtoc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int DEPTH_BITS = 16;
	localparam int TOTAL_BITS = 16;
	localparam int BYTE_BITS  = 8;
	// Width used to compare the count against the largest total.
	localparam int CMP_BITS   = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

	localparam logic [BYTE_BITS-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [BYTE_BITS-1:0] CH_RBRACKET = 8'h5D;
	localparam logic [BYTE_BITS-1:0] CH_LBRACE   = 8'h7B;
	localparam logic [BYTE_BITS-1:0] CH_RBRACE   = 8'h7D;
	localparam logic [BYTE_BITS-1:0] CH_QUOTE    = 8'h22;
	localparam logic [BYTE_BITS-1:0] CH_BSLASH   = 8'h5C;
	localparam logic [BYTE_BITS-1:0] CH_COMMA    = 8'h2C;
	localparam logic [BYTE_BITS-1:0] CH_SPACE    = 8'h20;
	localparam logic [BYTE_BITS-1:0] CH_TAB      = 8'h09;
	localparam logic [BYTE_BITS-1:0] CH_LF       = 8'h0A;
	localparam logic [BYTE_BITS-1:0] CH_CR       = 8'h0D;

	// Saturating count of non-whitespace bytes.
	localparam logic [1:0] NS_NONE = 2'd0;
	localparam logic [1:0] NS_ONE  = 2'd1;
	localparam logic [1:0] NS_MANY = 2'd2;

	typedef struct packed {
		logic                  escape_pending;
		logic                  inside_string;
		logic [DEPTH_BITS-1:0] brace_level;
		logic                  depth_overflowed;
		logic [COUNT_BITS-1:0] objects_seen;
		logic                  content_seen;
		logic                  content_before_latest;
		logic [1:0]            nonspace_count;
		logic                  opened_with_bracket;
		logic                  latest_is_close_bracket;
	} scan_state_t;

	function automatic logic is_blank(input logic [BYTE_BITS-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

>>> sv/json_top_level_object_counter_unit.sv
// Top level of the JSON object counter: scan state register, per-byte logic and output register.
// Depends on jtoc_pkg, jtoc_scan and jtoc_out_reg.
`timescale 1ns / 1ps

// Counts the objects that open at brace depth zero inside the top-level array of a JSON
// document streamed one byte per item, with tlast on the document's final byte. One byte is
// taken every cycle: the scan state is updated in the cycle the byte is accepted, and the
// final byte loads the count (or 0 for a malformed, unbalanced, empty or unterminated document)
// into the output register, which delivers it in the next cycle. Input is held off only while
// a previous result is waiting and not being taken. After each final byte the block is ready
// for the next document at once; no configuration is needed.
module json_top_level_object_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte[7:0]
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // object_total[15:0]
);

	jtoc_pkg::scan_state_t           state_q;
	jtoc_pkg::scan_state_t           state_next;
	logic [jtoc_pkg::TOTAL_BITS-1:0] object_total;
	logic                            out_free;
	logic                            accept;

	assign s_tready = out_free;
	assign accept   = s_tvalid && out_free;

	jtoc_scan u_scan (
		.state        (state_q),
		.text_byte    (s_tdata),
		.final_byte   (s_tlast),
		.state_next   (state_next),
		.object_total (object_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	jtoc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && s_tlast),
		.load_data (object_total),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	// An empty output register never holds off input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// A final byte yields a result in the next cycle and leaves the scan state cleared.
	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (m_tvalid && (state_q == '0)))
		else $error("final byte did not produce a result or clear the state");

	// A non-final byte never creates a result on its own.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tlast && (!m_tvalid || m_tready)) |=> !m_tvalid)
		else $error("result appeared without a final byte");
`endif

endmodule

>>> sv/jtoc_scan.sv
// Per-byte next-state and result logic of the JSON object counter.
// Purely combinational; depends on jtoc_pkg for the state type and character codes.
`timescale 1ns / 1ps

module jtoc_scan (
	input  jtoc_pkg::scan_state_t                 state,
	input  logic [jtoc_pkg::BYTE_BITS-1:0]        text_byte,
	input  logic                                  final_byte,
	output jtoc_pkg::scan_state_t                 state_next,
	output logic [jtoc_pkg::TOTAL_BITS-1:0]       object_total
);

	always_comb begin
		jtoc_pkg::scan_state_t nxt;
		logic blank;
		logic do_scan;
		logic doc_ok;
		logic [jtoc_pkg::CMP_BITS-1:0] wide_total;

		nxt = state;
		blank = jtoc_pkg::is_blank(text_byte);
		do_scan = 1'b0;

		if (blank) begin
			do_scan = (state.nonspace_count != jtoc_pkg::NS_NONE);
		end else if (state.nonspace_count == jtoc_pkg::NS_NONE) begin
			nxt.opened_with_bracket = (text_byte == jtoc_pkg::CH_LBRACKET);
			nxt.nonspace_count = jtoc_pkg::NS_ONE;
		end else begin
			// Keep the emptiness flag from before this byte in case it is the closing bracket.
			nxt.content_before_latest = state.content_seen;
			do_scan = 1'b1;
			nxt.latest_is_close_bracket = (text_byte == jtoc_pkg::CH_RBRACKET);
			nxt.nonspace_count = jtoc_pkg::NS_MANY;
		end

		if (do_scan) begin
			if (state.escape_pending) begin
				nxt.escape_pending = 1'b0;
			end else if (state.inside_string) begin
				if (text_byte == jtoc_pkg::CH_BSLASH) begin
					nxt.escape_pending = 1'b1;
				end else if (text_byte == jtoc_pkg::CH_QUOTE) begin
					nxt.inside_string = 1'b0;
				end
			end else begin
				case (text_byte)
					jtoc_pkg::CH_QUOTE: begin
						nxt.inside_string = 1'b1;
						nxt.content_seen = 1'b1;
					end
					jtoc_pkg::CH_LBRACE: begin
						if ((state.brace_level == '0) && (state.objects_seen != '1)) begin
							nxt.objects_seen = state.objects_seen + 1'b1;
						end
						if (state.brace_level != '1) begin
							nxt.brace_level = state.brace_level + 1'b1;
						end else begin
							nxt.depth_overflowed = 1'b1;
						end
						nxt.content_seen = 1'b1;
					end
					jtoc_pkg::CH_RBRACE: begin
						// An unmatched close brace at depth zero is ignored.
						if (state.brace_level != '0) begin
							nxt.brace_level = state.brace_level - 1'b1;
						end
					end
					default: begin
						if (!blank && (text_byte != jtoc_pkg::CH_COMMA)) begin
							nxt.content_seen = 1'b1;
						end
					end
				endcase
			end
		end

		doc_ok = (nxt.nonspace_count == jtoc_pkg::NS_MANY) && nxt.opened_with_bracket &&
			nxt.latest_is_close_bracket && !nxt.inside_string &&
			(nxt.brace_level == '0) && !nxt.depth_overflowed && nxt.content_before_latest;

		wide_total = doc_ok ? jtoc_pkg::CMP_BITS'(nxt.objects_seen) : '0;
		if (wide_total > jtoc_pkg::CMP_BITS'({jtoc_pkg::TOTAL_BITS{1'b1}})) begin
			object_total = '1;
		end else begin
			object_total = wide_total[jtoc_pkg::TOTAL_BITS-1:0];
		end

		// The document ends here: start the next one from the reset state.
		if (final_byte) begin
			nxt = '0;
		end
		state_next = nxt;
	end

endmodule

>>> sv/jtoc_out_reg.sv
// Output register of the JSON object counter: holds one result until it is taken.
// Depends on jtoc_pkg for the result width.
`timescale 1ns / 1ps

module jtoc_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [jtoc_pkg::TOTAL_BITS-1:0] load_data,
	output logic                            free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [jtoc_pkg::TOTAL_BITS-1:0] m_tdata
);

	logic                            valid_q;
	logic [jtoc_pkg::TOTAL_BITS-1:0] data_q;

	// A held result that is taken in this cycle frees the register for a new one.
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule
